// ----- rtl/spi_master_fifo_controller_defines.svh -----
// Assertion macros for the SPI master FIFO controller checkers.
// Self-contained; each macro expects signals named clk and rst_n in scope.
`ifndef SPI_MASTER_FIFO_CONTROLLER_DEFINES_SVH
`define SPI_MASTER_FIFO_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMFC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smfc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smfc: next-cycle check failed");

`endif

// ----- rtl/smfc_pkg.sv -----
// Shared types and constants for the SPI master FIFO controller.
// No dependencies; the other RTL modules use it, all but the checker by import.
package smfc_pkg;

    // Stream payload widths.
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 56;
    localparam int WORD_W     = 16;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_DATA_SIZE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_FORMAT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PORT_ENABLE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOOPBACK     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_IRQ_MASK     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RX_DMA       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TX_DMA       = 3'd6;

    // Interrupt bit positions.
    localparam int IRQ_ROR = 0;
    localparam int IRQ_RT  = 1;
    localparam int IRQ_RX  = 2;
    localparam int IRQ_TX  = 3;

    // What an input item asks for.
    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_FRAME = 2'd3
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the accepted item and prefetch FIFO heads
        logic exec;   // update state and capture the result
    } ctrl_cmd_t;

    // One result item, lowest field in the lowest bits.
    typedef struct packed {
        logic [3:0]        pad;
        logic              push_dropped;
        logic              tx_dma_req;
        logic              rx_dma_req;
        logic              irq_any;
        logic [3:0]        masked_irq;
        logic [3:0]        raw_irq;
        logic [4:0]        status;
        logic              burst_last;
        logic              burst_first;
        logic [WORD_W-1:0] mosi_out;
        logic              frame_valid;
        logic [WORD_W-1:0] read_data;
    } result_t;

endpackage

// ----- rtl/smfc_fifo.sv -----
// Circular word FIFO with head pointer, fill count and registered head read.
// Depends on smfc_pkg.
module smfc_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fetch,
    input  logic                             push,
    input  logic                             pop,
    input  logic [smfc_pkg::WORD_W-1:0]      wdata,
    output logic [smfc_pkg::WORD_W-1:0]      rdata,
    output logic [$clog2(DEPTH+1)-1:0]       fill
);
    import smfc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [PTR_W:0]    tail_sum;
    logic [PTR_W-1:0]  tail;

    // Write address is head plus fill, wrapped once at the depth.
    always_comb
    begin
        tail_sum = {1'b0, head_reg} + (PTR_W+1)'(fill_reg);
        if (tail_sum >= (PTR_W+1)'(DEPTH))
        begin
            tail_sum = tail_sum - (PTR_W+1)'(DEPTH);
        end
        tail = tail_sum[PTR_W-1:0];
    end

    // Pointer and count updates.
    always_comb
    begin
        head_next = head_reg;
        if (pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        fill_next = fill_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    // Storage: one write port at the tail, one registered read at the head.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail] <= wdata;
        end
        if (fetch)
        begin
            rdata_reg <= mem[head_reg];
        end
    end

    assign rdata = rdata_reg;
    assign fill  = fill_reg;

endmodule

// ----- rtl/smfc_ctrl.sv -----
// Controller for the SPI master FIFO controller: handshakes and sequencing.
// Depends on smfc_pkg.
module smfc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output smfc_pkg::ctrl_cmd_t  cmd
);
    import smfc_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    // An item enters only when idle and the result slot is free or being drained.
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign cmd.load  = in_valid && in_ready;
    assign cmd.exec  = (state_reg == ST_EXEC);
    assign out_valid = out_valid_reg;

    // State and result-valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (cmd.load)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/smfc_datapath.sv -----
// Datapath: configuration registers, both FIFOs, burst and overrun state, result.
// Depends on smfc_pkg and smfc_fifo.
module smfc_datapath #(
    parameter int FIFO_DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  smfc_pkg::ctrl_cmd_t                 cmd,
    input  logic [smfc_pkg::IN_DATA_W-1:0]      in_data,
    input  logic [smfc_pkg::IN_USER_W-1:0]      in_user,
    input  logic                                cfg_write,
    input  logic [smfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [smfc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [smfc_pkg::OUT_DATA_W-1:0]     out_data
);
    import smfc_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration registers.
    logic [3:0] data_size_reg;
    logic       port_enable_reg;
    logic       loopback_reg;
    logic [3:0] irq_mask_reg;
    logic       rx_dma_reg;
    logic       tx_dma_reg;

    // Captured item.
    kind_t             kind_reg;
    logic [WORD_W-1:0] write_value_reg;
    logic [WORD_W-1:0] miso_reg;

    // Block state and result.
    logic    overrun_reg;
    logic    overrun_next;
    logic    in_burst_reg;
    logic    in_burst_next;
    result_t result_reg;
    result_t result_next;

    // FIFO interface.
    logic [WORD_W-1:0] tx_rdata;
    logic [WORD_W-1:0] rx_rdata;
    logic [WORD_W-1:0] rx_word;
    logic [CNT_W-1:0]  tx_fill;
    logic [CNT_W-1:0]  rx_fill;
    logic [CNT_W-1:0]  tx_fill_after;
    logic [CNT_W-1:0]  rx_fill_after;
    logic [WORD_W-1:0] frame_mask;
    logic              tx_full;
    logic              rx_full;
    logic              tx_push_ok;
    logic              rx_pop_ok;
    logic              frame_run;
    logic              rx_push_ok;
    logic [3:0]        raw_irq;

    // Configuration writes; frame format is accepted but has no effect on results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_size_reg   <= '0;
            port_enable_reg <= 1'b0;
            loopback_reg    <= 1'b0;
            irq_mask_reg    <= '0;
            rx_dma_reg      <= 1'b0;
            tx_dma_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DATA_SIZE:    data_size_reg   <= cfg_data;
                REG_FRAME_FORMAT: ;
                REG_PORT_ENABLE:  port_enable_reg <= cfg_data[0];
                REG_LOOPBACK:     loopback_reg    <= cfg_data[0];
                REG_IRQ_MASK:     irq_mask_reg    <= cfg_data;
                REG_RX_DMA:       rx_dma_reg      <= cfg_data[0];
                REG_TX_DMA:       tx_dma_reg      <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg        <= kind_t'(in_user);
            write_value_reg <= in_data[WORD_W-1:0];
            miso_reg        <= in_data[2*WORD_W-1:WORD_W];
        end
    end

    // Decisions for the captured item, taken against the fill counts before it.
    always_comb
    begin
        frame_mask = 16'hFFFF >> (4'd15 - data_size_reg);
        tx_full    = (tx_fill == CNT_W'(FIFO_DEPTH));
        rx_full    = (rx_fill == CNT_W'(FIFO_DEPTH));
        tx_push_ok = (kind_reg == KIND_PUSH) && !tx_full;
        rx_pop_ok  = (kind_reg == KIND_POP) && (rx_fill != '0);
        frame_run  = (kind_reg == KIND_FRAME) && port_enable_reg && (tx_fill != '0);
        rx_push_ok = frame_run && !rx_full;
        rx_word    = loopback_reg ? (tx_rdata & frame_mask) : (miso_reg & frame_mask);

        tx_fill_after = tx_fill + CNT_W'(tx_push_ok) - CNT_W'(frame_run);
        rx_fill_after = rx_fill + CNT_W'(rx_push_ok) - CNT_W'(rx_pop_ok);
    end

    // Overrun flag and burst tracking.
    always_comb
    begin
        overrun_next  = overrun_reg;
        in_burst_next = in_burst_reg;
        if ((kind_reg == KIND_CLEAR) && write_value_reg[IRQ_ROR])
        begin
            overrun_next = 1'b0;
        end
        if (frame_run && rx_full)
        begin
            overrun_next = 1'b1;
        end
        if (frame_run)
        begin
            in_burst_next = (tx_fill_after != '0);
        end
        else if (kind_reg == KIND_FRAME)
        begin
            in_burst_next = 1'b0;
        end
    end

    // Result assembly from the state after the item.
    always_comb
    begin
        raw_irq          = '0;
        raw_irq[IRQ_ROR] = overrun_next;
        raw_irq[IRQ_RT]  = 1'b0;
        raw_irq[IRQ_RX]  = (rx_fill_after != '0);
        raw_irq[IRQ_TX]  = (tx_fill_after != CNT_W'(FIFO_DEPTH));

        result_next              = '0;
        result_next.read_data    = rx_pop_ok ? rx_rdata : '0;
        result_next.frame_valid  = frame_run;
        result_next.mosi_out     = frame_run ? (tx_rdata & frame_mask) : '0;
        result_next.burst_first  = frame_run && !in_burst_reg;
        // A burst ends when a frame drains the transmit FIFO or a slot finds no frame.
        result_next.burst_last   = (kind_reg == KIND_FRAME) &&
                                   (frame_run ? (tx_fill_after == '0) : in_burst_reg);
        result_next.status[0]    = (tx_fill_after == '0);
        result_next.status[1]    = raw_irq[IRQ_TX];
        result_next.status[2]    = raw_irq[IRQ_RX];
        result_next.status[3]    = (rx_fill_after == CNT_W'(FIFO_DEPTH));
        result_next.status[4]    = in_burst_next;
        result_next.raw_irq      = raw_irq;
        result_next.masked_irq   = raw_irq & irq_mask_reg;
        result_next.irq_any      = |(raw_irq & irq_mask_reg);
        result_next.rx_dma_req   = port_enable_reg && rx_dma_reg && raw_irq[IRQ_RX];
        result_next.tx_dma_req   = port_enable_reg && tx_dma_reg && raw_irq[IRQ_TX];
        result_next.push_dropped = (kind_reg == KIND_PUSH) && tx_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overrun_reg  <= 1'b0;
            in_burst_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            overrun_reg  <= overrun_next;
            in_burst_reg <= in_burst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    assign out_data = result_reg;

    // Transmit and receive FIFOs.
    smfc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_tx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .fetch (cmd.load),
        .push  (cmd.exec && tx_push_ok),
        .pop   (cmd.exec && frame_run),
        .wdata (write_value_reg),
        .rdata (tx_rdata),
        .fill  (tx_fill)
    );

    smfc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_rx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .fetch (cmd.load),
        .push  (cmd.exec && rx_push_ok),
        .pop   (cmd.exec && rx_pop_ok),
        .wdata (rx_word),
        .rdata (rx_rdata),
        .fill  (rx_fill)
    );

endmodule

// ----- rtl/spi_master_fifo_controller.sv -----
// Each accepted item has its FIFO heads read into registers at acceptance, then
// passes through the EXEC state, which updates the state and registers the result.
// No new item is taken until the controller is back in idle and the result slot
// is free or being drained.
// Reset (rst_n, asynchronous, active low) clears configuration, pointers, fill
// counts, overrun and burst state; FIFO storage is not cleared and needs no pass.
module spi_master_fifo_controller #(
    parameter int FIFO_DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input items.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [smfc_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // write_value, miso_in
    input  logic [smfc_pkg::IN_USER_W-1:0]      s_axis_tuser,  // kind
    // Result items.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_data, frame_valid, mosi_out, burst_first, burst_last, status,
    // raw_irq, masked_irq, irq_any, rx_dma_req, tx_dma_req, push_dropped, zero pad
    output logic [smfc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Configuration writes.
    input  logic                                cfg_write,
    input  logic [smfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [smfc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import smfc_pkg::*;

    ctrl_cmd_t cmd;

    smfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    smfc_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_axis_tdata)
    );

endmodule

// ----- rtl/smfc_checker.sv -----
// Port-level checks for spi_master_fifo_controller, bound to the top level.
// Depends on smfc_pkg and the assertion macro header.
`include "spi_master_fifo_controller_defines.svh"

module smfc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [smfc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    // A stalled result stays offered.
    `SMFC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // No item enters while a finished result is stalled.
    `SMFC_ASSERT_IMPLY(a_no_accept_stalled, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

    // Every accepted item has its result offered once the controller leaves EXEC.
    `SMFC_ASSERT_NEXT(a_result_follows, s_axis_tvalid && s_axis_tready, ##1 m_axis_tvalid)

    // The summary interrupt agrees with the masked interrupt bits.
    `SMFC_ASSERT_IMPLY(a_irq_any, m_axis_tvalid, m_axis_tdata[48] == (|m_axis_tdata[47:44]))

endmodule

bind spi_master_fifo_controller smfc_checker u_smfc_checker (.*);
